// ===== rtl/bb3_pkg.sv =====
`timescale 1ns / 1ps

package bb3_pkg;

  localparam int BB3_MAX_WIDTH  = 256;
  localparam int BB3_PIX_W      = 8;
  localparam int BB3_DIM_W      = 9;
  localparam int BB3_WIDTH_RST  = 256;
  localparam int BB3_HEIGHT_RST = 256;
  localparam int BB3_MIN_DIM    = 2;
  localparam int BB3_CFG_IDX_W  = 2;

  // Nine pixels of 8 bits sum to at most 2295.
  localparam int BB3_SUM_W      = 12;

  // Truncated division by 4, 6 and 9 as multiply by 2^15 / n, rounded up.
  localparam int BB3_RECIP_SHIFT = 15;
  localparam int BB3_RECIP_W     = 14;
  localparam int BB3_RECIP_4     = 8192;
  localparam int BB3_RECIP_6     = 5462;
  localparam int BB3_RECIP_9     = 3641;

  // Result buffer; also sets how many results may be in flight.
  localparam int BB3_FIFO_DEPTH = 8;

  typedef enum logic [BB3_CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_t;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    DIV_BY_4 = 2'd0,
    DIV_BY_6 = 2'd1,
    DIV_BY_9 = 2'd2
  } div_sel_t;

  // Neighborhood clipping for one output pixel.
  typedef struct packed {
    logic emit;
    logic last;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } pos_ctrl_t;

  typedef struct packed {
    logic                 vld;
    logic                 last;
    div_sel_t             sel;
    logic [BB3_SUM_W-1:0] sum;
  } sum_item_t;

  typedef struct packed {
    logic                 last;
    logic [BB3_PIX_W-1:0] pix;
  } out_item_t;

endpackage

// ===== rtl/bb3_line_store.sv =====
`timescale 1ns / 1ps

module bb3_line_store
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = BB3_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  col,
  input  logic                          par,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_col,
  input  logic [BB3_PIX_W-1:0]          wr_pix,
  output logic [BB3_PIX_W-1:0]          top,
  output logic [BB3_PIX_W-1:0]          mid
);

  // One bank per row parity; bank par holds the older row at this column.
  logic [BB3_PIX_W-1:0] bank0_mem [MAX_WIDTH];
  logic [BB3_PIX_W-1:0] bank1_mem [MAX_WIDTH];
  logic [BB3_PIX_W-1:0] q0_r;
  logic [BB3_PIX_W-1:0] q1_r;
  logic                 par_r;

  always_ff @(posedge clk) begin
    if (wr_en && !par) begin
      bank0_mem[wr_col] <= wr_pix;
    end
    if (rd_en) begin
      q0_r <= bank0_mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && par) begin
      bank1_mem[wr_col] <= wr_pix;
    end
    if (rd_en) begin
      q1_r <= bank1_mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      par_r <= par;
    end
  end

  assign top = par_r ? q1_r : q0_r;
  assign mid = par_r ? q0_r : q1_r;

endmodule

// ===== rtl/bb3_window.sv =====
`timescale 1ns / 1ps

module bb3_window
  import bb3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift,
  input  logic [BB3_PIX_W-1:0] col_top,
  input  logic [BB3_PIX_W-1:0] col_mid,
  input  logic [BB3_PIX_W-1:0] col_bot,
  input  pos_ctrl_t            pos,
  output sum_item_t            sum_o
);

  localparam int ROW_SUM_W = BB3_PIX_W + 2;

  logic [BB3_PIX_W-1:0] win_r   [3][3];
  logic [BB3_PIX_W-1:0] win_nxt [3][3];
  logic [BB3_PIX_W-1:0] col_new [3];
  pos_ctrl_t            pos_r;
  sum_item_t            sum_r;
  sum_item_t            sum_nxt;
  logic                 row_ok [3];
  logic                 col_ok [3];
  logic [ROW_SUM_W-1:0] row_sum [3];

  assign col_new[0] = col_top;
  assign col_new[1] = col_mid;
  assign col_new[2] = col_bot;

  // Column 2 is the newest, column 0 the oldest.
  always_comb begin
    win_nxt = win_r;
    if (shift) begin
      for (int r = 0; r < 3; r++) begin
        win_nxt[r][0] = win_r[r][1];
        win_nxt[r][1] = win_r[r][2];
        win_nxt[r][2] = col_new[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '{default: '0};
      pos_r <= '0;
    end else begin
      win_r <= win_nxt;
      pos_r <= pos;
    end
  end

  // Masked sum of the clipped neighborhood.
  always_comb begin
    row_ok[0] = pos_r.top_ok;
    row_ok[1] = 1'b1;
    row_ok[2] = pos_r.bot_ok;
    col_ok[0] = pos_r.left_ok;
    col_ok[1] = 1'b1;
    col_ok[2] = pos_r.right_ok;
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = (col_ok[0] ? ROW_SUM_W'(win_r[r][0]) : '0)
                 + ROW_SUM_W'(win_r[r][1])
                 + (col_ok[2] ? ROW_SUM_W'(win_r[r][2]) : '0);
      if (!row_ok[r]) begin
        row_sum[r] = '0;
      end
    end
    sum_nxt.vld  = pos_r.emit;
    sum_nxt.last = pos_r.last;
    sum_nxt.sum  = BB3_SUM_W'(row_sum[0]) + BB3_SUM_W'(row_sum[1])
                 + BB3_SUM_W'(row_sum[2]);
    priority if (pos_r.top_ok && pos_r.bot_ok && pos_r.left_ok && pos_r.right_ok) begin
      sum_nxt.sel = DIV_BY_9;
    end else if ((pos_r.top_ok && pos_r.bot_ok) || (pos_r.left_ok && pos_r.right_ok)) begin
      sum_nxt.sel = DIV_BY_6;
    end else begin
      sum_nxt.sel = DIV_BY_4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_o = sum_r;

endmodule

// ===== rtl/bb3_div.sv =====
`timescale 1ns / 1ps

module bb3_div
  import bb3_pkg::*;
(
  input  sum_item_t sum_i,
  output logic      push,
  output out_item_t item
);

  localparam int PROD_W = BB3_SUM_W + BB3_RECIP_W;

  logic [BB3_RECIP_W-1:0] recip;
  logic [PROD_W-1:0]      prod;

  // Reciprocal multiply; exact for every sum the window can produce.
  always_comb begin
    unique case (sum_i.sel)
      DIV_BY_4: recip = BB3_RECIP_W'(BB3_RECIP_4);
      DIV_BY_6: recip = BB3_RECIP_W'(BB3_RECIP_6);
      DIV_BY_9: recip = BB3_RECIP_W'(BB3_RECIP_9);
      default:  recip = BB3_RECIP_W'(BB3_RECIP_9);
    endcase
    prod      = PROD_W'(sum_i.sum) * PROD_W'(recip);
    item.pix  = prod[BB3_RECIP_SHIFT +: BB3_PIX_W];
    item.last = sum_i.last;
    push      = sum_i.vld;
  end

endmodule

// ===== rtl/bb3_out_fifo.sv =====
`timescale 1ns / 1ps

module bb3_out_fifo
  import bb3_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  input  logic      pop_ready,
  output logic      pop_valid,
  output out_item_t pop_item
);

  localparam int PTR_W  = $clog2(BB3_FIFO_DEPTH);
  localparam int FILL_W = $clog2(BB3_FIFO_DEPTH + 1);

  out_item_t         mem_r [BB3_FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic              pop;

  assign pop_valid = (fill_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      fill_r <= fill_r + FILL_W'(push) - FILL_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fill_r != FILL_W'(BB3_FIFO_DEPTH)))
    else $error("result buffer written while full");

endmodule

// ===== rtl/box_blur_3x3_clipped.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in_       slave      in_tvalid/in_tready   tdata: pixel_in; tuser: action
// out_      master     out_tvalid/out_tready tdata: pixel_out; tlast: frame_end
// cfg_      slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One item per clock while in_tready is high. A result for an accepted item
// passes line store read, window shift, masked sum, then reciprocal divide
// into the result buffer before it is presented.
// in_tready drops only while eight results are accepted but not yet taken;
// the credit count is registered, so out_tready never reaches in_tready.
// Reset is synchronous; the line store is not cleared (entries outside the
// frame are masked, never used). cfg_ready is always high.

module box_blur_3x3_clipped
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = BB3_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [BB3_PIX_W-1:0]     in_tdata,   // [7:0] pixel_in
  input  logic                     in_tuser,   // [0] action
  // result stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [BB3_PIX_W-1:0]     out_tdata,  // [7:0] pixel_out
  output logic                     out_tlast,  // frame_end
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [BB3_CFG_IDX_W-1:0] cfg_index,
  input  logic [BB3_DIM_W-1:0]     cfg_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = CW + 1;
  localparam int CNT_W  = $clog2(BB3_FIFO_DEPTH + 1);
  localparam int EW_RST = (BB3_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : BB3_WIDTH_RST;

  // effective frame size, already clamped
  logic [WW-1:0]        ew_r, ew_nxt;
  logic [BB3_DIM_W-1:0] eh_r, eh_nxt;

  // raster position of the next input pixel and the next output pixel
  logic [BB3_DIM_W-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0]        in_col_r, in_col_nxt;
  logic [BB3_DIM_W-1:0] out_row_r, out_row_nxt;
  logic [CW-1:0]        out_col_r, out_col_nxt;

  // results accepted but not yet transferred out
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // first pipeline stage
  logic                 s1_shift_r;
  logic [BB3_PIX_W-1:0] s1_bot_r;
  pos_ctrl_t            s1_pos_r;

  logic                 is_pix, draining, in_acc, cfg_wr, cfg_hit, pop;
  logic                 ready_pix, emit, shift, out_col_last;
  logic [WW-1:0]        w_m1;
  logic [BB3_DIM_W-1:0] h_m1;
  logic [BB3_DIM_W-1:0] base_row;
  logic [CW-1:0]        base_col;
  logic [CW-1:0]        rd_col;
  logic                 rd_par;
  pos_ctrl_t            pos;

  logic [BB3_PIX_W-1:0] col_top, col_mid;
  sum_item_t            sum_item;
  logic                 push;
  out_item_t            push_item, pop_item;

  assign cfg_ready = 1'b1;
  assign in_tready = (cnt_r < CNT_W'(BB3_FIFO_DEPTH));

  always_comb begin
    is_pix  = (in_tuser == ACT_PIXEL);
    in_acc  = in_tvalid && in_tready;
    cfg_wr  = cfg_valid && cfg_ready;
    cfg_hit = cfg_wr && ((cfg_index == CFG_FRAME_WIDTH) || (cfg_index == CFG_FRAME_HEIGHT));
    pop     = out_tvalid && out_tready;
    w_m1    = ew_r - WW'(1);
    h_m1    = eh_r - BB3_DIM_W'(1);

    // Input has wrapped to a new frame while the old frame's tail is still owed.
    draining = (in_row_r == '0) && (in_col_r == '0)
            && ((out_row_r != '0) || (out_col_r != '0));

    // A pixel during drain drops the owed tail and restarts output.
    base_row = (is_pix && draining) ? '0 : out_row_r;
    base_col = (is_pix && draining) ? '0 : out_col_r;

    ready_pix = (in_row_r[BB3_DIM_W-1:1] != '0)
             || ((in_row_r == BB3_DIM_W'(1)) && (in_col_r != '0));
    emit  = is_pix ? ready_pix : draining;
    shift = is_pix || draining;

    // Pick the column to pull from the line store; a flush fetches the column
    // right of the output pixel, banks swapped; at the last column, column 0.
    out_col_last = (WW'(out_col_r) == w_m1);
    priority if (is_pix) begin
      rd_col = in_col_r;
      rd_par = in_row_r[0];
    end else if (out_col_last) begin
      rd_col = '0;
      rd_par = out_row_r[0];
    end else begin
      rd_col = out_col_r + CW'(1);
      rd_par = ~out_row_r[0];
    end

    // Only an accepted item that owes a result marks the stage valid.
    pos.emit     = in_acc && emit;
    pos.top_ok   = (base_row != '0);
    pos.bot_ok   = (base_row != h_m1);
    pos.left_ok  = (base_col != '0);
    pos.right_ok = (WW'(base_col) != w_m1);
    pos.last     = !pos.bot_ok && !pos.right_ok;

    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (cfg_hit) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
    end else if (in_acc) begin
      if (is_pix) begin
        if (WW'(in_col_r) == w_m1) begin
          in_col_nxt = '0;
          in_row_nxt = (in_row_r == h_m1) ? '0 : in_row_r + BB3_DIM_W'(1);
        end else begin
          in_col_nxt = in_col_r + CW'(1);
        end
        out_row_nxt = base_row;
        out_col_nxt = base_col;
      end
      if (emit) begin
        priority if (pos.last) begin
          out_row_nxt = '0;
          out_col_nxt = '0;
        end else if (!pos.right_ok) begin
          out_row_nxt = base_row + BB3_DIM_W'(1);
          out_col_nxt = '0;
        end else begin
          out_row_nxt = base_row;
          out_col_nxt = base_col + CW'(1);
        end
      end
    end

    // Clamp width to 2..MAX_WIDTH and height to at least 2.
    ew_nxt = ew_r;
    eh_nxt = eh_r;
    if (cfg_wr && (cfg_index == CFG_FRAME_WIDTH)) begin
      priority if (cfg_data < BB3_DIM_W'(BB3_MIN_DIM)) begin
        ew_nxt = WW'(BB3_MIN_DIM);
      end else if (32'(cfg_data) > MAX_WIDTH) begin
        ew_nxt = WW'(MAX_WIDTH);
      end else begin
        ew_nxt = WW'(cfg_data);
      end
    end
    if (cfg_wr && (cfg_index == CFG_FRAME_HEIGHT)) begin
      eh_nxt = (cfg_data < BB3_DIM_W'(BB3_MIN_DIM)) ? BB3_DIM_W'(BB3_MIN_DIM) : cfg_data;
    end

    cnt_nxt = cnt_r + CNT_W'(in_acc && emit) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ew_r       <= WW'(EW_RST);
      eh_r       <= BB3_DIM_W'(BB3_HEIGHT_RST);
      in_row_r   <= '0;
      in_col_r   <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      cnt_r      <= '0;
      s1_shift_r <= 1'b0;
      s1_pos_r   <= '0;
    end else begin
      ew_r          <= ew_nxt;
      eh_r          <= eh_nxt;
      in_row_r      <= in_row_nxt;
      in_col_r      <= in_col_nxt;
      out_row_r     <= out_row_nxt;
      out_col_r     <= out_col_nxt;
      cnt_r         <= cnt_nxt;
      s1_shift_r    <= in_acc && shift;
      s1_pos_r      <= pos;
    end
  end

  // Bottom row of the new window column: the pixel itself, zero on flush.
  always_ff @(posedge clk) begin
    s1_bot_r <= is_pix ? in_tdata : '0;
  end

  bb3_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk    (clk),
    .rd_en  (in_acc && shift),
    .col    (rd_col),
    .par    (rd_par),
    .wr_en  (in_acc && is_pix),
    .wr_col (in_col_r),
    .wr_pix (in_tdata),
    .top    (col_top),
    .mid    (col_mid)
  );

  bb3_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .shift   (s1_shift_r),
    .col_top (col_top),
    .col_mid (col_mid),
    .col_bot (s1_bot_r),
    .pos     (s1_pos_r),
    .sum_o   (sum_item)
  );

  bb3_div u_div (
    .sum_i (sum_item),
    .push  (push),
    .item  (push_item)
  );

  bb3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop_ready (out_tready),
    .pop_valid (out_tvalid),
    .pop_item  (pop_item)
  );

  assign out_tdata = pop_item.pix;
  assign out_tlast = pop_item.last;

  a_cols_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (WW'(in_col_r) < ew_r) && (WW'(out_col_r) < ew_r))
    else $error("column counter beyond frame width");

  a_rows_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_row_r < eh_r) && (out_row_r < eh_r))
    else $error("row counter beyond frame height");

  a_credit_covers_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (cnt_r != '0))
    else $error("result presented without an outstanding credit");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bb3_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  // Pipeline is four stages deep; give it a few spare cycles before config writes.
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 20;
  localparam int RANDOM_ITEMS  = 250;
  localparam int IDLE_PCT      = 33;
  localparam longint TIMEOUT_NS = 2_000_000;

  // Register indexes that the block decodes to nothing.
  localparam logic [BB3_CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [BB3_CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  typedef enum int {FILL_RANDOM, FILL_BLACK, FILL_WHITE, FILL_BINARY} fill_t;

  typedef struct {
    logic [BB3_PIX_W-1:0] pix;
    logic                 last;
  } blur_px_t;

  // DUT ports; every input starts at a known value.
  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [BB3_PIX_W-1:0]     in_tdata   = '0;
  logic                     in_tuser   = ACT_PIXEL;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [BB3_PIX_W-1:0]     out_tdata;
  logic                     out_tlast;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [BB3_CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BB3_DIM_W-1:0]     cfg_data   = '0;

  // Blur predictor state: line store banks, 3x3 window, raster positions.
  bit [BB3_PIX_W-1:0] blur_store [0:2*BB3_MAX_WIDTH-1];
  bit [BB3_PIX_W-1:0] blur_win [0:8];
  int                 src_row, src_col, dst_row, dst_col;
  logic [BB3_DIM_W-1:0] reg_width, reg_height;

  blur_px_t expected_px[$];

  bit gaps_on = 1'b1;
  int fail_count;
  int items_sent;
  int pixels_seen;
  int frame_ends_seen;
  int geometries;

  box_blur_3x3_clipped DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver: stall about a third of the cycles unless gaps are switched off.
  always @(posedge clk) begin
    out_tready <= gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Blur predictor
  // ---------------------------------------------------------------------------

  // Width saturates to 2..MAX_WIDTH, height is only raised to 2.
  function automatic int eff_width();
    int w;
    w = reg_width;
    if (w < BB3_MIN_DIM) w = BB3_MIN_DIM;
    if (w > BB3_MAX_WIDTH) w = BB3_MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    return (reg_height < BB3_MIN_DIM) ? BB3_MIN_DIM : int'(reg_height);
  endfunction

  // One bank per row parity.
  function automatic int store_addr(int bank, int col);
    return (bank % 2) * BB3_MAX_WIDTH + (col % BB3_MAX_WIDTH);
  endfunction

  // Output is pending when input sits at the frame origin but output does not.
  function automatic bit frame_draining();
    return src_row == 0 && src_col == 0 && (dst_row != 0 || dst_col != 0);
  endfunction

  task automatic shift_window(bit [7:0] top, bit [7:0] mid, bit [7:0] bot);
    bit [7:0] col_in [0:2];
    col_in[0] = top;
    col_in[1] = mid;
    col_in[2] = bot;
    for (int r = 0; r < 3; r++) begin
      blur_win[3*r]     = blur_win[3*r + 1];
      blur_win[3*r + 1] = blur_win[3*r + 2];
      blur_win[3*r + 2] = col_in[r];
    end
  endtask

  // Average the window clipped to the frame and advance the output position.
  task automatic emit_blurred();
    int w, h, rr, cc, sum, cnt;
    blur_px_t px;
    w   = eff_width();
    h   = eff_height();
    sum = 0;
    cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      rr = dst_row + dr;
      if (rr >= 0 && rr < h) begin
        for (int dc = -1; dc <= 1; dc++) begin
          cc = dst_col + dc;
          if (cc >= 0 && cc < w) begin
            sum += blur_win[(dr + 1) * 3 + (dc + 1)];
            cnt++;
          end
        end
      end
    end
    if (cnt == 0) cnt = 1;
    px.pix  = 8'(sum / cnt);
    px.last = (dst_row == h - 1 && dst_col == w - 1);
    expected_px.push_back(px);
    dst_col++;
    if (dst_col >= w) begin
      dst_col = 0;
      dst_row++;
      if (dst_row >= h) dst_row = 0;
    end
    if (px.last) begin
      dst_row = 0;
      dst_col = 0;
    end
  endtask

  task automatic blur_predict(action_t act, logic [7:0] pix);
    int  w, h, r, c;
    bit  ready;
    w = eff_width();
    h = eff_height();
    if (act == ACT_PIXEL) begin
      // A pixel while draining drops what is left of the previous frame.
      if (frame_draining()) begin
        dst_row = 0;
        dst_col = 0;
      end
      r = src_row;
      c = src_col;
      shift_window(blur_store[store_addr(r, c)], blur_store[store_addr(r + 1, c)], pix);
      blur_store[store_addr(r, c)] = pix;
      ready = r >= 2 || (r == 1 && c >= 1);
      src_col++;
      if (src_col >= w) begin
        src_col = 0;
        src_row++;
        if (src_row >= h) src_row = 0;
      end
      if (ready) emit_blurred();
    end else if (frame_draining()) begin
      // Flush: feed a zero bottom row; rows come from the stores swapped, except at the last column.
      if (dst_col + 1 < w) begin
        shift_window(blur_store[store_addr(dst_row + 1, dst_col + 1)],
                     blur_store[store_addr(dst_row, dst_col + 1)], 8'h00);
      end else begin
        shift_window(blur_store[store_addr(dst_row, 0)],
                     blur_store[store_addr(dst_row + 1, 0)], 8'h00);
      end
      emit_blurred();
    end
  endtask

  // A register write restarts the frame; spare indexes change nothing.
  task automatic blur_config(logic [BB3_CFG_IDX_W-1:0] idx, logic [BB3_DIM_W-1:0] val);
    if (idx == CFG_FRAME_WIDTH) begin
      reg_width = val;
    end else if (idx == CFG_FRAME_HEIGHT) begin
      reg_height = val;
    end else begin
      return;
    end
    src_row = 0;
    src_col = 0;
    dst_row = 0;
    dst_col = 0;
  endtask

  task automatic blur_reset();
    reg_width  = BB3_WIDTH_RST;
    reg_height = BB3_HEIGHT_RST;
    foreach (blur_store[i]) blur_store[i] = '0;
    foreach (blur_win[i]) blur_win[i] = '0;
    src_row = 0;
    src_col = 0;
    dst_row = 0;
    dst_col = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare every output transfer with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    blur_px_t exp_px;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_px.size() == 0) begin
        $error("unexpected result: pixel_out=%0d frame_end=%0b", out_tdata, out_tlast);
        fail_count++;
      end else begin
        exp_px = expected_px.pop_front();
        pixels_seen++;
        if (out_tlast) frame_ends_seen++;
        if (out_tdata !== exp_px.pix) begin
          $error("pixel_out: expected %0d, got %0d", exp_px.pix, out_tdata);
          fail_count++;
        end
        if (out_tlast !== exp_px.last) begin
          $error("frame_end: expected %0b, got %0b", exp_px.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Transfer one input item, with a random gap before it when gaps are on.
  task automatic send_item(action_t act, logic [7:0] pix);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    blur_predict(act, pix);
  endtask

  // Drop valid and hold the sender until every expected result has arrived.
  task automatic hold_input_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_px.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [BB3_CFG_IDX_W-1:0] idx, logic [BB3_DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    blur_config(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Let the block go idle, then set a new frame geometry.
  task automatic write_geometry(logic [BB3_DIM_W-1:0] width_val,
                                logic [BB3_DIM_W-1:0] height_val);
    hold_input_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_cfg(CFG_FRAME_WIDTH, width_val);
    write_cfg(CFG_FRAME_HEIGHT, height_val);
    geometries++;
  endtask

  function automatic logic [7:0] pick_pixel(fill_t fill);
    case (fill)
      FILL_BLACK:  return 8'h00;
      FILL_WHITE:  return 8'hFF;
      FILL_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
      default:     return 8'($urandom);
    endcase
  endfunction

  // Stream rows*w pixels; optionally scatter stray flushes, and sometimes drain midway.
  task automatic send_frame(int w, int rows, fill_t fill, bit stray_flush);
    for (int i = 0; i < w * rows; i++) begin
      if (stray_flush && $urandom_range(7) == 0) send_item(ACT_FLUSH, 8'($urandom));
      if (i == (w * rows) / 2 && $urandom_range(15) == 0) hold_input_until_drained();
      send_item(ACT_PIXEL, pick_pixel(fill));
    end
  endtask

  task automatic send_flushes(int n);
    repeat (n) send_item(ACT_FLUSH, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry is 256x256: a flush finds nothing, first-row pixels give nothing.
  task automatic test_reset_state();
    send_item(ACT_FLUSH, 8'hFF);
    send_item(ACT_PIXEL, 8'hFF);
    send_item(ACT_PIXEL, 8'h00);
  endtask

  task automatic test_directed();
    // Width 1 and height 0 both clamp to the 2x2 minimum.
    write_geometry(9'd1, 9'd0);
    write_cfg(CFG_IDX_SPARE_LO, 9'h1FF);
    write_cfg(CFG_IDX_SPARE_HI, 9'h000);
    // All-white 2x2 frame: four corner averages, last one marks frame end.
    repeat (4) send_item(ACT_PIXEL, 8'hFF);
    send_flushes(3);
    // Nothing left to drain.
    send_item(ACT_FLUSH, 8'h00);
    // 3x3 checkerboard reaches corner, edge and center averages.
    write_geometry(9'd3, 9'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_item(ACT_FLUSH, 8'hA5);
      send_item(ACT_PIXEL, (i % 2) ? 8'hFF : 8'h00);
    end
    // Drain only part of the tail, let it all come out, then start over.
    send_flushes(2);
    hold_input_until_drained();
    send_item(ACT_PIXEL, 8'h7F);
  endtask

  // Full rate on both sides for a few frames.
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    write_geometry(9'd8, 9'd4);
    repeat (3) begin
      send_frame(8, 4, FILL_RANDOM, 1'b0);
      send_flushes(9);
    end
    hold_input_until_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int    start, w, h, kind;
    fill_t fill;
    logic [BB3_DIM_W-1:0] wv, hv;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      wv = ($urandom_range(9) == 0) ? 9'($urandom_range(1)) : 9'($urandom_range(2, 12));
      hv = ($urandom_range(9) == 0) ? 9'($urandom_range(1)) : 9'($urandom_range(2, 6));
      write_geometry(wv, hv);
      w = eff_width();
      h = eff_height();
      repeat ($urandom_range(1, 3)) begin
        fill = ($urandom_range(3) != 0) ? FILL_RANDOM : fill_t'($urandom_range(3));
        kind = $urandom_range(99);
        if (kind < 75) begin
          send_frame(w, h, fill, 1'b0);
          send_flushes(w + 1);
        end else if (kind < 85) begin
          send_frame(w, h, fill, 1'b1);
          send_flushes(w + 1);
        end else if (kind < 93) begin
          // Short drain: the next pixel drops the rest of the tail.
          send_frame(w, h, fill, 1'b0);
          send_flushes($urandom_range(0, w));
        end else begin
          repeat ($urandom_range(1, 2 * w)) send_item(action_t'($urandom_range(1)),
                                                      8'($urandom));
        end
      end
    end
  endtask

  task automatic test_size_extremes();
    // Width 511 saturates to the full line length.
    write_geometry(9'd511, 9'd2);
    send_frame(eff_width(), 2, FILL_RANDOM, 1'b0);
    send_flushes(eff_width() + 1);
    // Tallest frame: run part of it, then a flush that finds nothing pending.
    write_geometry(9'd0, 9'd511);
    send_frame(eff_width(), 40, FILL_RANDOM, 1'b0);
    send_item(ACT_FLUSH, 8'h00);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    blur_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed();
    test_back_to_back();
    test_random_frames();
    test_size_extremes();

    // Wait out the tail, then give stray results a chance to show up.
    hold_input_until_drained();
    repeat (END_CYCLES) @(posedge clk);

    $display("Sent %0d input items over %0d frame geometries (2x2 up to 256 wide, 511 tall).",
             items_sent, geometries);
    $display("Checked %0d blurred pixels including %0d frame ends.",
             pixels_seen, frame_ends_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: generous bound on the whole run.
  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
